>>> rtl/tra_pkg.sv
// Shared types, opcodes and state encodings for the tiny register ALU core.
`default_nettype none

package tra_pkg;

    // Datapath width and divider iteration count
    localparam int unsigned DATA_W = 32;
    localparam int unsigned DIV_W  = 32;
    localparam int unsigned CNT_W  = $clog2(DIV_W);

    // Opcodes
    localparam logic [7:0] OP_AND  = 8'd1;
    localparam logic [7:0] OP_OR   = 8'd2;
    localparam logic [7:0] OP_XOR  = 8'd3;
    localparam logic [7:0] OP_DIV  = 8'd128;
    localparam logic [7:0] OP_MUL  = 8'd129;
    localparam logic [7:0] OP_ADD  = 8'd130;
    localparam logic [7:0] OP_SUB  = 8'd131;
    localparam logic [7:0] OP_MOV  = 8'd132;
    localparam logic [7:0] OP_NOT  = 8'd68;
    localparam logic [7:0] OP_DEC  = 8'd192;
    localparam logic [7:0] OP_INC  = 8'd193;
    localparam logic [7:0] OP_SSGN = 8'd194;
    localparam logic [7:0] OP_ISGN = 8'd195;

    // Mask applied by NOT
    localparam logic [DATA_W-1:0] NOT_MASK = 32'd255;

    typedef struct packed {
        logic [7:0]  op;
        logic        op2_is_immediate;
        logic        op2_positive;
        logic [3:0]  op1_reg;
        logic [15:0] op2_value;
    } t_instr;

    typedef struct packed {
        logic [3:0]         dest_reg;
        logic signed [31:0] write_value;
        logic               did_write;
        logic [15:0]        next_pc;
        logic               div_by_zero;
        logic               out_of_program;
    } t_result;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_DONE
    } t_core_state;

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_FIN
    } t_div_state;

endpackage

`default_nettype wire

>>> rtl/tra_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
`default_nettype none

module tra_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [tra_pkg::DATA_W-1:0]    i_dividend,
    input  wire logic [tra_pkg::DATA_W-1:0]    i_divisor,
    output tra_pkg::t_div_status               o_status,
    output logic      [tra_pkg::DATA_W-1:0]    o_quotient
);

    localparam int unsigned W = tra_pkg::DATA_W;

    tra_pkg::t_div_state r_state, n_state;

    logic [W-1:0]                r_rem;
    logic [W-1:0]                r_q;
    logic [W-1:0]                r_d;
    logic                        r_neg;
    logic [tra_pkg::CNT_W-1:0]   r_cnt;

    logic [W:0] w_shift;
    logic [W:0] w_diff;

    assign w_shift = {r_rem, r_q[W-1]};
    assign w_diff  = w_shift - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tra_pkg::D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_status   = '0;
        o_quotient = r_neg ? (W'(0) - r_q) : r_q;
        case (r_state)
            tra_pkg::D_IDLE: begin
                if (i_start) begin
                    n_state = tra_pkg::D_RUN;
                end
            end
            tra_pkg::D_RUN: begin
                o_status.busy = 1'b1;
                if (r_cnt == tra_pkg::CNT_W'(tra_pkg::DIV_W - 1)) begin
                    n_state = tra_pkg::D_FIN;
                end
            end
            tra_pkg::D_FIN: begin
                o_status.busy = 1'b1;
                o_status.done = 1'b1;
                n_state       = tra_pkg::D_IDLE;
            end
            default: begin
                n_state = tra_pkg::D_IDLE;
            end
        endcase
    end

    // Load magnitudes at start, then shift one bit a cycle
    always_ff @(posedge i_clk) begin
        if (r_state == tra_pkg::D_IDLE && i_start) begin
            r_neg <= i_dividend[W-1] ^ i_divisor[W-1];
            r_q   <= i_dividend[W-1] ? (W'(0) - i_dividend) : i_dividend;
            r_d   <= i_divisor[W-1] ? (W'(0) - i_divisor) : i_divisor;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_state == tra_pkg::D_RUN) begin
            r_cnt <= r_cnt + 1'b1;
            if (!w_diff[W]) begin
                r_rem <= w_diff[W-1:0];
                r_q   <= {r_q[W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[W-1:0];
                r_q   <= {r_q[W-2:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/tiny_register_alu_core.sv
// Top level of the tiny register ALU core: register file, sequencer and result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one decoded
//   instruction per item. Output channel (o_out_valid / i_out_ready /
//   o_out_item) returns exactly one result item per instruction, in order.
//   i_cfg_we / i_cfg_data write program_length; write it only while idle.
// Sequencing and throughput:
//   Most instructions read both register operands from the register file on
//   accept, then execute and commit. DIV with a non-zero divisor also runs
//   the divider, which produces one
//   quotient bit per cycle (start, 32 steps, sign fix). The block takes one
//   item at a time and is ready again once the result is registered.
// Reset (synchronous, i_rst_n low): clears the sequencer, program counter,
//   halt flag, register valid bits (all registers read as zero) and sets
//   program_length to 65535.
// Stall: a result waits in the output register while i_out_ready is low;
//   a further result parks in a holding register and the core stays busy,
//   not ready for a new item, until the output register frees.
`default_nettype none

module tiny_register_alu_core #(
    parameter int unsigned REG_COUNT   = 16,
    parameter int unsigned INSTR_BYTES = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire tra_pkg::t_instr  i_in_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output tra_pkg::t_result      o_out_item,
    input  wire logic             i_cfg_we,
    input  wire logic [15:0]      i_cfg_data
);

    localparam int unsigned W     = tra_pkg::DATA_W;
    localparam int unsigned IDX_W = $clog2(REG_COUNT);

    // Map a 4-bit register field onto the register file, wrapping at REG_COUNT
    function automatic logic [3:0] reg_idx(input logic [3:0] v);
        logic [3:0] res;
        int         m;
        res = '0;
        m   = 0;
        for (int k = 0; k < 16; k++) begin
            if (4'(k) == v) begin
                res = 4'(m);
            end
            m = (m == int'(REG_COUNT) - 1) ? 0 : m + 1;
        end
        return res;
    endfunction

    // Register file: memory with a valid bit per entry so reset reads as zero
    logic [W-1:0]           r_regs [REG_COUNT];
    logic [REG_COUNT-1:0]   r_reg_vld;

    // Sequencer and architectural state
    tra_pkg::t_core_state   r_state, n_state;
    logic [15:0]            r_pc;
    logic                   r_halt;
    logic [15:0]            r_prog_len;

    // Captured item and operand reads
    tra_pkg::t_instr        r_item;
    logic [3:0]             r_dst4;
    logic [W-1:0]           r_x_raw;
    logic [W-1:0]           r_y_raw;
    logic                   r_x_vld;
    logic                   r_y_vld;

    // Result parking and output registers
    tra_pkg::t_result       r_res;
    logic                   r_out_vld;
    tra_pkg::t_result       r_out_item;

    // Combinational datapath
    logic [3:0]             w_x_idx4;
    logic [3:0]             w_y_idx4;
    logic [W-1:0]           w_x;
    logic [W-1:0]           w_y;
    logic [W-1:0]           w_imm;
    logic [W-1:0]           w_alu;
    logic [16:0]            w_pc_sum;
    logic                   w_oop;
    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_commit;
    tra_pkg::t_result       w_commit_item;
    logic                   w_div_start;
    tra_pkg::t_div_status   w_div_st;
    logic [W-1:0]           w_div_q;

    assign w_accept    = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == tra_pkg::S_IDLE);
    assign w_out_free  = !r_out_vld || i_out_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    assign w_x_idx4 = reg_idx(i_in_item.op1_reg);
    assign w_y_idx4 = reg_idx(i_in_item.op2_value[3:0]);

    // Operand read on accept, register write on commit
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item  <= i_in_item;
            r_dst4  <= w_x_idx4;
            r_x_raw <= r_regs[IDX_W'(w_x_idx4)];
            r_y_raw <= r_regs[IDX_W'(w_y_idx4)];
            r_x_vld <= r_reg_vld[IDX_W'(w_x_idx4)];
            r_y_vld <= r_reg_vld[IDX_W'(w_y_idx4)];
        end
        if (w_commit && !r_halt) begin
            r_regs[IDX_W'(r_dst4)] <= w_commit_item.write_value;
        end
    end

    assign w_x   = r_x_vld ? r_x_raw : '0;
    assign w_imm = {16'b0, r_item.op2_value};
    assign w_y   = r_item.op2_is_immediate
                   ? (r_item.op2_positive ? w_imm : (W'(0) - w_imm))
                   : (r_y_vld ? r_y_raw : '0);

    always_comb begin
        case (r_item.op)
            tra_pkg::OP_AND:  w_alu = w_x & w_y;
            tra_pkg::OP_OR:   w_alu = w_x | w_y;
            tra_pkg::OP_XOR:  w_alu = w_x ^ w_y;
            tra_pkg::OP_ADD:  w_alu = w_x + w_y;
            tra_pkg::OP_SUB:  w_alu = w_x - w_y;
            tra_pkg::OP_MUL:  w_alu = W'(w_x * w_y);
            tra_pkg::OP_MOV:  w_alu = w_y;
            tra_pkg::OP_NOT:  w_alu = w_x ^ tra_pkg::NOT_MASK;
            tra_pkg::OP_DEC:  w_alu = w_x - W'(1);
            tra_pkg::OP_INC:  w_alu = w_x + W'(1);
            tra_pkg::OP_SSGN: w_alu = (w_y[W-1] && w_x == W'(1)) ? (W'(0) - w_y) : '0;
            tra_pkg::OP_ISGN: w_alu = W'(0) - w_x;
            default:          w_alu = '0;
        endcase
    end

    // Program counter check against the program length
    assign w_pc_sum = {1'b0, r_pc} + 17'(INSTR_BYTES);
    assign w_oop    = w_pc_sum > {1'b0, r_prog_len};

    tra_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_x),
        .i_divisor  (w_y),
        .o_status   (w_div_st),
        .o_quotient (w_div_q)
    );

    // Next state and commit
    always_comb begin
        n_state       = r_state;
        w_commit      = 1'b0;
        w_div_start   = 1'b0;
        w_commit_item = '0;

        w_commit_item.dest_reg       = r_dst4;
        w_commit_item.write_value    = w_alu;
        w_commit_item.did_write      = 1'b1;
        w_commit_item.next_pc        = w_oop ? r_pc : w_pc_sum[15:0];
        w_commit_item.out_of_program = w_oop;
        w_commit_item.div_by_zero    = 1'b0;

        case (r_state)
            tra_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = tra_pkg::S_EXEC;
                end
            end
            tra_pkg::S_EXEC: begin
                if (r_halt) begin
                    // Halted: report the frozen state, change nothing
                    w_commit                     = 1'b1;
                    w_commit_item                = '0;
                    w_commit_item.next_pc        = r_pc;
                    w_commit_item.out_of_program = 1'b1;
                end else if (r_item.op == tra_pkg::OP_DIV && w_y != '0) begin
                    w_div_start = 1'b1;
                    n_state     = tra_pkg::S_DIV;
                end else begin
                    w_commit = 1'b1;
                    if (r_item.op == tra_pkg::OP_DIV) begin
                        w_commit_item.write_value = '0;
                        w_commit_item.div_by_zero = 1'b1;
                    end
                end
                if (w_commit) begin
                    n_state = w_out_free ? tra_pkg::S_IDLE : tra_pkg::S_DONE;
                end
            end
            tra_pkg::S_DIV: begin
                if (w_div_st.done) begin
                    w_commit                  = 1'b1;
                    w_commit_item.write_value = w_div_q;
                    n_state = w_out_free ? tra_pkg::S_IDLE : tra_pkg::S_DONE;
                end
            end
            tra_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = tra_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tra_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tra_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Architectural state: program counter, halt, valid bits, config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= '0;
            r_halt     <= 1'b0;
            r_reg_vld  <= '0;
            r_prog_len <= 16'hFFFF;
        end else begin
            if (i_cfg_we) begin
                r_prog_len <= i_cfg_data;
            end
            if (w_commit && !r_halt) begin
                r_reg_vld[IDX_W'(r_dst4)] <= 1'b1;
                if (w_oop) begin
                    r_halt <= 1'b1;
                end else begin
                    r_pc <= w_pc_sum[15:0];
                end
            end
        end
    end

    // Hold every committed result, for use when the output register is still occupied
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_res <= w_commit_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_commit && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (r_state == tra_pkg::S_DONE && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit && w_out_free) begin
            r_out_item <= w_commit_item;
        end else if (r_state == tra_pkg::S_DONE && w_out_free) begin
            r_out_item <= r_res;
        end
    end

    // An accepted item always goes to execute next
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == tra_pkg::S_EXEC))
        else $error("accepted item did not enter execute");

    // Only reset leaves the halted state
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared without reset");

    // Program counter moves only on a commit
    a_pc_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_commit |=> $stable(r_pc))
        else $error("program counter changed without a commit");

    // Divider is never restarted while busy
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_st.busy)
        else $error("divider started while busy");

    // A result without a write is a halted result
    a_nowrite_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.did_write) |-> o_out_item.out_of_program)
        else $error("result without write not flagged as overrun");

endmodule

`default_nettype wire
